// ----- rtl/cwg_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the weight-gradient engine.
package cwg_pkg;

    localparam int MAX_SIDE   = 32;
    localparam int MAX_FILTER = 8;

    localparam int ROW_W    = 5;
    localparam int VAL_W    = 16;
    localparam int TAP_W    = 3;
    localparam int SUM_W    = 48;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int STRIDE_W = 4;
    localparam int FILT_W   = 4;
    localparam int SIZE_W   = 6;
    localparam int CFG_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int WIN_W    = ROW_W + STRIDE_W;

    localparam int ACT_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ACT_AW    = $clog2(ACT_DEPTH);
    localparam int SUM_DEPTH = MAX_FILTER * MAX_FILTER;
    localparam int SUM_AW    = $clog2(SUM_DEPTH);

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 56;

    localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(1);
    localparam logic [FILT_W-1:0]   FILTER_RST = FILT_W'(3);
    localparam logic [SIZE_W-1:0]   HEIGHT_RST = SIZE_W'(28);
    localparam logic [SIZE_W-1:0]   WIDTH_RST  = SIZE_W'(28);

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_GRAD  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRIDE = 2'd0,
        CFG_FILTER = 2'd1,
        CFG_HEIGHT = 2'd2,
        CFG_WIDTH  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic capture;
        logic act_write;
        logic tap_issue;
        logic sums_clear;
        logic push_ack;
        logic push_sum;
    } cwg_cmd_t;

    typedef struct packed {
        req_t req;
        logic item_err;
        logic tap_last;
        logic rd_last;
        logic pipe_busy;
        logic out_free;
    } cwg_stat_t;

endpackage

// ----- rtl/conv_weight_gradient.sv -----
// Top level of the single-channel 2D convolution weight-gradient engine.
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------------
//   s_*      | in        | tuser: req_type[1:0]; tdata: row, col, value (Q1.15)
//   m_*      | out       | tdata: tap_row, tap_col, grad_sum; tlast: last;
//            |           | tuser: status
//   cfg_*    | in        | index 0 stride, 1 filter_size, 2 in_height, 3 in_width
//
// A load or clear item is executed and then acknowledged; a gradient item walks
// its taps, one tap per cycle through the shared MAC (store read, multiply,
// add/saturate/write) plus the drain; a readout emits one sum per cycle while the
// output register is free, out of the single sum-store read port.
// One item is in work at a time; s_tready is high only while the engine is idle.
// Reset clears the sum bank (valid bits) and loads the register reset values;
// the activation store holds garbage until loaded. A stalled m_tready holds the
// output register and freezes the sequencer at its next push.
module conv_weight_gradient
    import cwg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // row[4:0], col[9:5], value[25:10], zero pad
    input  logic [1:0]           s_tuser,   // req_type[1:0]
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // tap_row[2:0], tap_col[5:3], grad_sum[53:6], pad
    output logic                 m_tuser,   // status[0]
    output logic                 m_tlast
);

    cwg_cmd_t  cmd;
    cwg_stat_t stat;

    // sequencer: accept, decode, walk taps, push results
    cwg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stores, MAC pipeline and output register
    cwg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- rtl/cwg_ctrl.sv -----
// Sequencing state machine: decodes each item and drives the datapath commands.
module cwg_ctrl
    import cwg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  cwg_stat_t stat,
    output cwg_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GRAD_RUN,
        ST_GRAD_DRAIN,
        ST_ACK,
        ST_READ_PUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (stat.req)
                    REQ_LOAD:
                    begin
                        cmd.act_write = !stat.item_err;
                        state_next    = ST_ACK;
                    end
                    REQ_GRAD:
                    begin
                        state_next = stat.item_err ? ST_ACK : ST_GRAD_RUN;
                    end
                    REQ_CLEAR:
                    begin
                        cmd.sums_clear = 1'b1;
                        state_next     = ST_ACK;
                    end
                    REQ_READ:
                    begin
                        cmd.tap_issue = 1'b1;
                        state_next    = ST_READ_PUSH;
                    end
                    default:
                    begin
                        state_next = ST_ACK;
                    end
                endcase
            end
            ST_GRAD_RUN:
            begin
                cmd.tap_issue = 1'b1;
                if (stat.tap_last)
                begin
                    state_next = ST_GRAD_DRAIN;
                end
            end
            ST_GRAD_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_ACK;
                end
            end
            ST_ACK:
            begin
                if (stat.out_free)
                begin
                    cmd.push_ack = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_READ_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.push_sum = 1'b1;
                    if (stat.rd_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.tap_issue = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/cwg_datapath.sv -----
// Datapath: configuration, item capture, activation and sum stores, MAC pipeline, output register.
module cwg_datapath
    import cwg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [1:0]             s_tuser,
    input  cwg_cmd_t               cmd,
    output cwg_stat_t              stat,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // configuration
    logic [STRIDE_W-1:0] stride_reg;
    logic [FILT_W-1:0]   filter_reg;
    logic [SIZE_W-1:0]   height_reg;
    logic [SIZE_W-1:0]   width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= STRIDE_RST;
            filter_reg <= FILTER_RST;
            height_reg <= HEIGHT_RST;
            width_reg  <= WIDTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_STRIDE: stride_reg <= cfg_data[STRIDE_W-1:0];
                CFG_FILTER: filter_reg <= cfg_data[FILT_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                default:    stride_reg <= stride_reg;
            endcase
        end
    end

    logic [STRIDE_W-1:0] s_eff;
    logic [FILT_W-1:0]   f_eff;
    logic [SIZE_W-1:0]   h_eff;
    logic [SIZE_W-1:0]   w_eff;
    logic [TAP_W-1:0]    f_m1;

    assign s_eff = (stride_reg == '0) ? STRIDE_W'(1) : stride_reg;
    assign f_eff = (filter_reg == '0) ? FILT_W'(1)
                 : (filter_reg > FILT_W'(MAX_FILTER)) ? FILT_W'(MAX_FILTER) : filter_reg;
    assign h_eff = (height_reg > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : height_reg;
    assign w_eff = (width_reg > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : width_reg;
    assign f_m1  = TAP_W'(f_eff - FILT_W'(1));

    // captured item
    req_t                    req_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [ROW_W-1:0]        col_reg;
    logic signed [VAL_W-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_t'(s_tuser);
            row_reg   <= s_tdata[ROW_W-1:0];
            col_reg   <= s_tdata[2*ROW_W-1:ROW_W];
            value_reg <= s_tdata[2*ROW_W+VAL_W-1:2*ROW_W];
        end
    end

    // window origin and range checks
    logic [WIN_W-1:0] win_row;
    logic [WIN_W-1:0] win_col;
    logic             load_err;
    logic             grad_err;
    logic             item_err;

    assign win_row  = WIN_W'(row_reg) * WIN_W'(s_eff);
    assign win_col  = WIN_W'(col_reg) * WIN_W'(s_eff);
    assign load_err = (SIZE_W'(row_reg) >= h_eff) || (SIZE_W'(col_reg) >= w_eff);
    assign grad_err = ((WIN_W+1)'(win_row) + (WIN_W+1)'(f_eff) > (WIN_W+1)'(h_eff))
                   || ((WIN_W+1)'(win_col) + (WIN_W+1)'(f_eff) > (WIN_W+1)'(w_eff));

    always_comb
    begin
        unique case (req_reg)
            REQ_LOAD: item_err = load_err;
            REQ_GRAD: item_err = grad_err;
            default:  item_err = 1'b0;
        endcase
    end

    // tap walk, raster order
    logic [TAP_W-1:0] tap_i_reg;
    logic [TAP_W-1:0] tap_k_reg;
    logic             tap_last;

    assign tap_last = (tap_i_reg == f_m1) && (tap_k_reg == f_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_i_reg <= '0;
            tap_k_reg <= '0;
        end
        else if (cmd.capture)
        begin
            tap_i_reg <= '0;
            tap_k_reg <= '0;
        end
        else if (cmd.tap_issue)
        begin
            if (tap_k_reg == f_m1)
            begin
                tap_k_reg <= '0;
                tap_i_reg <= tap_i_reg + TAP_W'(1);
            end
            else
            begin
                tap_k_reg <= tap_k_reg + TAP_W'(1);
            end
        end
    end

    // addresses
    logic [ROW_W-1:0]  act_row;
    logic [ROW_W-1:0]  act_col;
    logic [ACT_AW-1:0] act_addr;
    logic [SUM_AW-1:0] tap_addr;

    assign act_row  = cmd.act_write ? row_reg : ROW_W'(win_row + WIN_W'(tap_i_reg));
    assign act_col  = cmd.act_write ? col_reg : ROW_W'(win_col + WIN_W'(tap_k_reg));
    assign act_addr = ACT_AW'(int'(act_row) * MAX_SIDE + int'(act_col));
    assign tap_addr = SUM_AW'(int'(tap_i_reg) * MAX_FILTER + int'(tap_k_reg));

    // activation store, no reset
    logic signed [VAL_W-1:0] act_mem [ACT_DEPTH];
    logic signed [VAL_W-1:0] act_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.act_write)
        begin
            act_mem[act_addr] <= value_reg;
        end
        if (cmd.tap_issue)
        begin
            act_rd_reg <= act_mem[act_addr];
        end
    end

    // gradient sum store, with per-entry valid bits standing for the zero reset
    logic signed [SUM_W-1:0] sum_mem [SUM_DEPTH];
    logic [SUM_DEPTH-1:0]    sum_vld_reg;
    logic signed [SUM_W-1:0] sum_rd_reg;
    logic                    sum_rd_vld_reg;
    logic signed [SUM_W-1:0] sum_rd_val;

    // pipeline stage registers
    logic                     s1_valid_reg;
    logic [SUM_AW-1:0]        s1_addr_reg;
    logic [TAP_W-1:0]         rd_i_reg;
    logic [TAP_W-1:0]         rd_k_reg;
    logic                     rd_last_reg;
    logic                     s2_valid_reg;
    logic [SUM_AW-1:0]        s2_addr_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  base_reg;

    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;

    assign sum_rd_val = sum_rd_vld_reg ? sum_rd_reg : '0;
    assign sum_wide   = {base_reg[SUM_W-1], base_reg} + (SUM_W+1)'(prod_reg);

    always_comb
    begin
        priority if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            sum_mem[s2_addr_reg] <= sum_sat;
        end
        if (cmd.tap_issue)
        begin
            sum_rd_reg <= sum_mem[tap_addr];
            s1_addr_reg <= tap_addr;
            rd_i_reg    <= tap_i_reg;
            rd_k_reg    <= tap_k_reg;
            rd_last_reg <= tap_last;
        end
        if (s1_valid_reg)
        begin
            prod_reg    <= act_rd_reg * value_reg;
            base_reg    <= sum_rd_val;
            s2_addr_reg <= s1_addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_vld_reg    <= '0;
            sum_rd_vld_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.sums_clear)
            begin
                sum_vld_reg <= '0;
            end
            else if (s2_valid_reg)
            begin
                sum_vld_reg[s2_addr_reg] <= 1'b1;
            end
            if (cmd.tap_issue)
            begin
                sum_rd_vld_reg <= sum_vld_reg[tap_addr];
            end
            s1_valid_reg <= cmd.tap_issue && (req_reg == REQ_GRAD);
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // output register
    logic                    out_valid_reg;
    logic [TAP_W-1:0]        out_row_reg;
    logic [TAP_W-1:0]        out_col_reg;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic                    out_last_reg;
    logic                    out_status_reg;
    logic                    out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_ack || cmd.push_sum)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_ack)
        begin
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_sum_reg    <= '0;
            out_last_reg   <= 1'b1;
            out_status_reg <= item_err;
        end
        else if (cmd.push_sum)
        begin
            out_row_reg    <= rd_i_reg;
            out_col_reg    <= rd_k_reg;
            out_sum_reg    <= sum_rd_val;
            out_last_reg   <= rd_last_reg;
            out_status_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_sum_reg, out_col_reg, out_row_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    assign stat.req       = req_reg;
    assign stat.item_err  = item_err;
    assign stat.tap_last  = tap_last;
    assign stat.rd_last   = rd_last_reg;
    assign stat.pipe_busy = s1_valid_reg || s2_valid_reg;
    assign stat.out_free  = out_free;

endmodule
